// ===== rtl/lrts_pkg.sv =====
// shared constants, types and tables of the line reflection texel shader
// no dependencies; imported by every module in rtl/

package lrts_pkg;

	localparam int COORD_BITS    = 12;
	localparam int FRAC_BITS     = 16;
	localparam int DIM_BITS      = COORD_BITS + 1;
	localparam int GAIN_BITS     = 17;
	localparam int GAIN_FRAC     = 16;
	localparam int GQ            = 30;
	localparam int ZW            = $clog2(FRAC_BITS + 1);
	localparam int LOG_BITS      = FRAC_BITS + ZW;
	localparam int SHIN_SCALE    = 255;
	localparam int EXP_BITS      = GAIN_BITS + 8;
	localparam int GRAY_BITS     = 8;
	localparam int ALPHA_VAL     = 127;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = GAIN_BITS;
	localparam int IN_DATA_BITS  = ((2 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = 2 * GRAY_BITS;

	// stage counts of the two long units
	localparam int NORM_LAT = 2 * FRAC_BITS + 4;
	localparam int POW_LAT  = 2 * FRAC_BITS + 4;

	typedef logic [FRAC_BITS:0] fix_t;

	localparam fix_t ONE = {1'b1, {FRAC_BITS{1'b0}}};

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_AMBIENT      = 3'd2,
		REG_DIFFUSE      = 3'd3,
		REG_SPECULAR     = 3'd4,
		REG_SHININESS    = 3'd5
	} cfg_reg_t;

	typedef logic [GQ-1:0] root_tab_t [FRAC_BITS];

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bv;
		rem = v;
		res = '0;
		bv  = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + bv) begin
				rem = rem - (res + bv);
				res = (res >> 1) + bv;
			end else begin
				res = res >> 1;
			end
			bv = bv >> 2;
		end
		return res;
	endfunction

	// r_k = 2^(-2^-(k+1)) in Q0.30, each the root of the one before, the first the root of one half
	function automatic root_tab_t gen_root_tab();
		root_tab_t tab;
		logic [63:0] r;
		r = 64'd1 << (GQ - 1);
		for (int k = 0; k < FRAC_BITS; k++) begin
			r = isqrt64(r << GQ);
			tab[k] = r[GQ-1:0];
		end
		return tab;
	endfunction

	localparam root_tab_t ROOT_TAB = gen_root_tab();

endpackage

// ===== rtl/line_reflection_texel_shader.sv =====
// top level of the line reflection texel shader: config registers, products,
// intensity sum and output register; uses lrts_pkg, lrts_norm and lrts_pow

// Usage
//   s_axis carries one texel coordinate per beat (row in bits 11:0, column in
//   bits 23:12); m_axis returns one beat per input beat, in order, with the
//   gray level in bits 7:0 and the alpha byte (always 127) in bits 15:8.
//   cfg_wr_en/cfg_index/cfg_data write the six registers; write them only
//   while no beat is in flight.
// Throughput: one beat per clock, sustained while no stall holds the pipeline.
// Pipeline: 76 register stages in all, the first loaded at the accepting edge.
//   The depth is set
//   by the two bit-per-stage units (divider plus square root per coordinate,
//   then log, exponent multiply and root product in the power unit), each
//   2*FRAC_BITS+4 stages deep, plus three product/sum stages and the output.
// Reset: arst_n clears all valid bits and loads the register reset values
//   (256 x 256 texture, ka 0, kd 0.5, kr 0.5, shininess 0.5).
// Stall: while m_axis_tready is low and a result sits in the output register,
//   the pipeline keeps moving as long as its last stage is empty; once that
//   stage is full it freezes as a whole and s_axis_tready drops. Nothing is
//   lost or repeated.

module line_reflection_texel_shader (
	input  logic                               clk,
	input  logic                               arst_n,
	// texel coordinate in: row [11:0], column [23:12]
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [lrts_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
	// texel out: gray_level [7:0], alpha_level [15:8]
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [lrts_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
	// register writes
	input  logic                               cfg_wr_en,
	input  logic [lrts_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [lrts_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import lrts_pkg::*;

	localparam int SUM_BITS = GAIN_BITS + FRAC_BITS + 2;

	// configuration registers
	logic [DIM_BITS-1:0]  width_q, height_q;
	logic [GAIN_BITS-1:0] ka_q, kd_q, kr_q, shin_q;
	logic [EXP_BITS-1:0]  expo;

	// pipeline control
	logic en;
	logic out_free;

	// coordinate units
	logic [COORD_BITS-1:0] row, column;
	logic nl_valid, nv_valid;
	fix_t lt, vt, sl, sv;
	logic negl, negv;

	// products and reflection term
	logic                   vld_s1, vld_s2, vld_s3;
	logic [2*FRAC_BITS+1:0] p1_c, p2_c;
	fix_t                   p1_s1, p2_s1, sl_s1;
	logic                   diff_s1;
	logic [FRAC_BITS+1:0]   dsum_c;
	fix_t                   d_c;
	fix_t                   d_s2, sl_s2;

	// power and diffuse delay
	logic pw_valid;
	fix_t pw;
	fix_t sld_s [0:POW_LAT-1];

	// intensity and output
	logic [SUM_BITS-1:0]            ka_t, kd_t, kr_t;
	logic [SUM_BITS-1:0]            inten_s3;
	fix_t                           clip_c;
	logic [FRAC_BITS+GRAY_BITS:0]   scaled_c;
	logic                           out_valid_q;
	logic [GRAY_BITS-1:0]           gray_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_BITS'(256);
			height_q <= DIM_BITS'(256);
			ka_q     <= '0;
			kd_q     <= GAIN_BITS'(32768);
			kr_q     <= GAIN_BITS'(32768);
			shin_q   <= GAIN_BITS'(32768);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[DIM_BITS-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[DIM_BITS-1:0];
				REG_AMBIENT:      ka_q     <= cfg_data[GAIN_BITS-1:0];
				REG_DIFFUSE:      kd_q     <= cfg_data[GAIN_BITS-1:0];
				REG_SPECULAR:     kr_q     <= cfg_data[GAIN_BITS-1:0];
				REG_SHININESS:    shin_q   <= cfg_data[GAIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// exponent in Q.16
	assign expo = EXP_BITS'(shin_q) * EXP_BITS'(SHIN_SCALE);

	// whole pipeline moves unless its last stage is full and the output slot is taken
	assign out_free      = ~out_valid_q | m_axis_tready;
	assign en            = out_free | ~vld_s3;
	assign s_axis_tready = en;

	assign row    = s_axis_tdata[COORD_BITS-1:0];
	assign column = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];

	lrts_norm u_norm_l (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.idx       (column),
		.dim       (width_q),
		.out_valid (nl_valid),
		.mag       (lt),
		.neg       (negl),
		.root      (sl)
	);

	lrts_norm u_norm_v (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.idx       (row),
		.dim       (height_q),
		.out_valid (nv_valid),
		.mag       (vt),
		.neg       (negv),
		.root      (sv)
	);

	// LT*VT and the product of the two roots
	assign p1_c = lt * vt;
	assign p2_c = sl * sv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= nl_valid & nv_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= pw_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1   <= p1_c[2*FRAC_BITS:FRAC_BITS];
			p2_s1   <= p2_c[2*FRAC_BITS:FRAC_BITS];
			sl_s1   <= sl;
			diff_s1 <= negl ^ negv;
		end
	end

	// reflection term: sum when the signs differ, else absolute difference; cap at one
	always_comb begin
		if (diff_s1) begin
			dsum_c = {1'b0, p1_s1} + {1'b0, p2_s1};
		end else if (p1_s1 >= p2_s1) begin
			dsum_c = {1'b0, p1_s1 - p2_s1};
		end else begin
			dsum_c = {1'b0, p2_s1 - p1_s1};
		end
		d_c = (dsum_c > {1'b0, ONE}) ? ONE : dsum_c[FRAC_BITS:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s2  <= d_c;
			sl_s2 <= sl_s1;
		end
	end

	lrts_pow u_pow (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s2),
		.base      (d_s2),
		.expo      (expo),
		.out_valid (pw_valid),
		.res       (pw)
	);

	// diffuse root rides alongside the power unit
	always_ff @(posedge clk) begin
		if (en) begin
			sld_s[0] <= sl_s2;
			for (int k = 1; k < POW_LAT; k++) begin
				sld_s[k] <= sld_s[k-1];
			end
		end
	end

	// gain terms, each floor(g*v/2^16)
	always_comb begin
		ka_t = SUM_BITS'(({ka_q, {FRAC_BITS{1'b0}}}) >> GAIN_FRAC);
		kd_t = (SUM_BITS'(kd_q) * SUM_BITS'(sld_s[POW_LAT-1])) >> GAIN_FRAC;
		kr_t = (SUM_BITS'(kr_q) * SUM_BITS'(pw)) >> GAIN_FRAC;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inten_s3 <= ka_t + kd_t + kr_t;
		end
	end

	// clamp at one and scale to a byte
	always_comb begin
		clip_c   = (inten_s3 > SUM_BITS'(ONE)) ? ONE : inten_s3[FRAC_BITS:0];
		scaled_c = clip_c * (FRAC_BITS + GRAY_BITS + 1)'(255);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && vld_s3) begin
			gray_q <= scaled_c[FRAC_BITS+GRAY_BITS-1:FRAC_BITS];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {GRAY_BITS'(ALPHA_VAL), gray_q};

endmodule

// ===== rtl/lrts_norm.sv =====
// one coordinate: |2(idx+1)-(dim+1)|/(dim+1) by a bit-per-stage divider,
// then sqrt(1-a^2) by a bit-per-stage square root; uses lrts_pkg

module lrts_norm (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [lrts_pkg::COORD_BITS-1:0] idx,
	input  logic [lrts_pkg::DIM_BITS-1:0]   dim,
	output logic                         out_valid,
	output lrts_pkg::fix_t               mag,
	output logic                         neg,
	output lrts_pkg::fix_t               root
);
	import lrts_pkg::*;

	localparam int UW = COORD_BITS + 2;
	localparam int RW = 2 * FRAC_BITS + 3;
	localparam int SQ = FRAC_BITS + 1;

	logic [NORM_LAT-1:0] vld_s;

	logic [UW-1:0]        t_c, u_c, m_c;
	logic [UW-1:0]        rem_s [0:FRAC_BITS];
	logic [UW-1:0]        div_s [0:FRAC_BITS];
	logic [FRAC_BITS-1:0] quo_s [0:FRAC_BITS];
	logic                 sat_s [0:FRAC_BITS];
	logic                 ng_s  [0:FRAC_BITS];

	fix_t                 a_s;
	logic                 na_s;

	logic [RW-1:0]        sr_s  [0:SQ];
	fix_t                 rt_s  [0:SQ];
	fix_t                 ac_s  [0:SQ];
	logic                 nc_s  [0:SQ];

	logic [2*FRAC_BITS+1:0] a_sq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NORM_LAT-2:0], in_valid};
		end
	end

	always_comb begin
		t_c = (UW'(idx) + UW'(1)) << 1;
		u_c = UW'(dim) + UW'(1);
		m_c = (t_c >= u_c) ? (t_c - u_c) : (u_c - t_c);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= m_c;
			div_s[0] <= u_c;
			quo_s[0] <= '0;
			sat_s[0] <= (m_c >= u_c);
			ng_s[0]  <= (t_c < u_c);
		end
	end

	// restoring divider, one quotient bit per stage
	for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_div
		logic [UW:0] sh;
		logic        ge;
		assign sh = {rem_s[k-1], 1'b0};
		assign ge = (sh >= {1'b0, div_s[k-1]});
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? UW'(sh - {1'b0, div_s[k-1]}) : sh[UW-1:0];
				div_s[k] <= div_s[k-1];
				quo_s[k] <= {quo_s[k-1][FRAC_BITS-2:0], ge};
				sat_s[k] <= sat_s[k-1];
				ng_s[k]  <= ng_s[k-1];
			end
		end
	end

	// saturate magnitudes at one
	always_ff @(posedge clk) begin
		if (en) begin
			a_s  <= sat_s[FRAC_BITS] ? ONE : {1'b0, quo_s[FRAC_BITS]};
			na_s <= ng_s[FRAC_BITS];
		end
	end

	assign a_sq = a_s * a_s;

	always_ff @(posedge clk) begin
		if (en) begin
			sr_s[0] <= {2'b00, FRAC_BITS'(ONE - fix_t'(a_sq >> FRAC_BITS)) , {FRAC_BITS{1'b0}}}
				| (RW'(a_sq[2*FRAC_BITS+1:FRAC_BITS] == '0) << (2 * FRAC_BITS));
			rt_s[0] <= '0;
			ac_s[0] <= a_s;
			nc_s[0] <= na_s;
		end
	end

	// digit-by-digit square root, one result bit per stage, msb first
	for (genvar j = 1; j <= SQ; j++) begin : g_sqrt
		localparam int B = SQ - j;
		logic [RW-1:0] trial;
		logic          ge;
		assign trial = (RW'(rt_s[j-1]) << (B + 1)) | (RW'(1) << (2 * B));
		assign ge    = (sr_s[j-1] >= trial);
		always_ff @(posedge clk) begin
			if (en) begin
				sr_s[j] <= ge ? (sr_s[j-1] - trial) : sr_s[j-1];
				rt_s[j] <= ge ? (rt_s[j-1] | (fix_t'(1) << B)) : rt_s[j-1];
				ac_s[j] <= ac_s[j-1];
				nc_s[j] <= nc_s[j-1];
			end
		end
	end

	assign out_valid = vld_s[NORM_LAT-1];
	assign mag       = ac_s[SQ];
	assign neg       = nc_s[SQ];
	assign root      = rt_s[SQ];

endmodule

// ===== rtl/lrts_pow.sv =====
// power b^e as 2^-(e*(-log2 b)): squaring log stages, one multiply,
// then a product of constant roots; uses lrts_pkg and its ROOT_TAB

module lrts_pow (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  lrts_pkg::fix_t                base,
	input  logic [lrts_pkg::EXP_BITS-1:0] expo,
	output logic                          out_valid,
	output lrts_pkg::fix_t                res
);
	import lrts_pkg::*;

	localparam int MW   = GQ + 1;
	localparam int PW   = LOG_BITS + EXP_BITS - GAIN_FRAC;
	localparam int FLEN = POW_LAT - 1;

	logic [POW_LAT-1:0] vld_s;
	logic [FLEN-1:0]    zero_s;
	logic [FLEN-1:0]    eone_s;

	logic [ZW-1:0]        pos_c;
	logic [ZW-1:0]        z_c;
	fix_t                 nb_c;

	logic [MW-1:0]        m_s  [0:FRAC_BITS];
	logic [ZW-1:0]        z_s  [0:FRAC_BITS];
	logic [FRAC_BITS-1:0] fr_s [0:FRAC_BITS];

	logic [LOG_BITS-1:0]  lg_s;
	logic [LOG_BITS+EXP_BITS-1:0] pr_c;
	logic [PW-1:0]        pv_c;

	logic [MW-1:0]        acc_s  [0:FRAC_BITS];
	logic [FRAC_BITS-1:0] f_s    [0:FRAC_BITS];
	logic [ZW-1:0]        n_s    [0:FRAC_BITS];
	logic                 kill_s [0:FRAC_BITS];

	fix_t                 res_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[POW_LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s <= {zero_s[FLEN-2:0], (base == '0)};
			eone_s <= {eone_s[FLEN-2:0], (expo == '0)};
		end
	end

	// leading one of the base, then normalize into [1,2) in Q1.30
	always_comb begin
		pos_c = '0;
		for (int i = 0; i <= FRAC_BITS; i++) begin
			if (base[i]) pos_c = ZW'(i);
		end
		z_c  = ZW'(FRAC_BITS) - pos_c;
		nb_c = fix_t'(base << z_c);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0]  <= {nb_c, {(GQ - FRAC_BITS){1'b0}}};
			z_s[0]  <= z_c;
			fr_s[0] <= '0;
		end
	end

	// log fraction by repeated squaring, one bit per stage
	for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_log
		logic [2*MW-1:0] mm;
		logic [MW:0]     t;
		assign mm = m_s[k-1] * m_s[k-1];
		assign t  = mm[GQ+MW:GQ];
		always_ff @(posedge clk) begin
			if (en) begin
				m_s[k]  <= t[MW] ? t[MW:1] : t[MW-1:0];
				z_s[k]  <= z_s[k-1];
				fr_s[k] <= {fr_s[k-1][FRAC_BITS-2:0], t[MW]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lg_s <= (LOG_BITS'(z_s[FRAC_BITS]) << FRAC_BITS) - LOG_BITS'(fr_s[FRAC_BITS]);
		end
	end

	assign pr_c = lg_s * expo;
	assign pv_c = PW'(pr_c >> GAIN_FRAC);

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s[0]  <= MW'(1) << GQ;
			f_s[0]    <= pv_c[FRAC_BITS-1:0];
			n_s[0]    <= ZW'(pv_c >> FRAC_BITS);
			kill_s[0] <= ((pv_c >> FRAC_BITS) > PW'(FRAC_BITS));
		end
	end

	// 2^-f as a product of constant roots, one fraction bit per stage
	for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_exp
		logic [MW+GQ-1:0] pp;
		assign pp = acc_s[k-1] * ROOT_TAB[k-1];
		always_ff @(posedge clk) begin
			if (en) begin
				acc_s[k]  <= f_s[k-1][FRAC_BITS-k] ? MW'(pp >> GQ) : acc_s[k-1];
				f_s[k]    <= f_s[k-1];
				n_s[k]    <= n_s[k-1];
				kill_s[k] <= kill_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (eone_s[FLEN-1]) begin
				res_s <= ONE;
			end else if (zero_s[FLEN-1] || kill_s[FRAC_BITS]) begin
				res_s <= '0;
			end else begin
				res_s <= fix_t'(acc_s[FRAC_BITS] >> (GQ - FRAC_BITS)) >> n_s[FRAC_BITS];
			end
		end
	end

	assign out_valid = vld_s[POW_LAT-1];
	assign res       = res_s;

endmodule
